>>> src/etb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event timer bank package
// Request, response and cell-to-cell carry types, mode codes and sizes.
// ----------------------------------------------------------------------------
package etb_pkg;

   localparam int SLOTS            = 8;
   localparam int CHANNELS_DEFAULT = 8;
   localparam int CHAN_BITS        = 3;
   localparam int COUNT_BITS       = 16;

   localparam logic [2:0] MODE_TICK    = 3'd0;
   localparam logic [2:0] MODE_START   = 3'd1;
   localparam logic [2:0] MODE_STOP    = 3'd2;
   localparam logic [2:0] MODE_RESTART = 3'd3;
   localparam logic [2:0] MODE_READ    = 3'd4;
   localparam logic [2:0] MODE_QUERY   = 3'd5;

   typedef struct packed {
      logic [2:0]            mode;
      logic [CHAN_BITS-1:0]  channel;
      logic [COUNT_BITS-1:0] period;
      logic                  recurring;
      logic                  clear_flag;
   } etb_req_type;

   typedef struct packed {
      logic                  granted;
      logic [CHAN_BITS-1:0]  granted_channel;
      logic [COUNT_BITS-1:0] count_value;
      logic                  expired;
      logic [SLOTS-1:0]      all_flags;
   } etb_rsp_type;

   typedef struct packed {
      logic                  valid;
      etb_req_type           req;
      logic                  granted;
      logic [CHAN_BITS-1:0]  granted_channel;
      logic [COUNT_BITS-1:0] count_value;
      logic                  expired;
   } etb_carry_type;

endpackage

>>> src/etb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event timer bank cell
// Holds one timer and applies the passing request to it, then hands it on.
// ----------------------------------------------------------------------------
module etb_cell import etb_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  etb_carry_type carry_i,
   output etb_carry_type carry_o,
   output logic          flag_o
);

   localparam logic [CHAN_BITS-1:0] MY_CHAN = CHAN_BITS'(INDEX);

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] reload_ff, reload_in;
   logic                  flag_ff, flag_in;
   etb_carry_type         carry_ff, carry_in;
   logic                  sel;
   logic                  free;

   assign sel  = (carry_i.req.channel == MY_CHAN);
   assign free = (count_ff == '0) && (reload_ff == '0);

   always_comb begin
      count_in  = count_ff;
      reload_in = reload_ff;
      flag_in   = flag_ff;
      carry_in  = carry_i;
      if (carry_i.valid) begin
         unique case (carry_i.req.mode)
            MODE_TICK: begin
               if (count_ff != '0) begin
                  if (count_ff == COUNT_BITS'(1)) begin
                     count_in = reload_ff;
                     flag_in  = 1'b1;
                  end else begin
                     count_in = count_ff - COUNT_BITS'(1);
                  end
               end
            end
            MODE_START: begin
               if (free && !carry_i.granted) begin
                  count_in = carry_i.req.period;
                  if (carry_i.req.recurring) begin
                     reload_in = carry_i.req.period;
                  end
                  flag_in                  = 1'b0;
                  carry_in.granted         = 1'b1;
                  carry_in.granted_channel = MY_CHAN;
               end
            end
            MODE_STOP: begin
               if (sel) begin
                  count_in  = '0;
                  reload_in = '0;
               end
            end
            MODE_RESTART: begin
               if (sel) begin
                  count_in = carry_i.req.period;
                  if (carry_i.req.recurring) begin
                     reload_in = carry_i.req.period;
                  end
                  flag_in = 1'b0;
               end
            end
            MODE_READ: begin
               if (sel) begin
                  carry_in.count_value = count_ff;
               end
            end
            MODE_QUERY: begin
               if (sel) begin
                  carry_in.expired = flag_ff;
                  if (carry_i.req.clear_flag) begin
                     flag_in = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         reload_ff      <= '0;
         flag_ff        <= 1'b0;
         carry_ff.valid <= 1'b0;
      end else begin
         count_ff       <= count_in;
         reload_ff      <= reload_in;
         flag_ff        <= flag_in;
         carry_ff.valid <= carry_in.valid;
      end
      carry_ff.req             <= carry_in.req;
      carry_ff.granted         <= carry_in.granted;
      carry_ff.granted_channel <= carry_in.granted_channel;
      carry_ff.count_value     <= carry_in.count_value;
      carry_ff.expired         <= carry_in.expired;
   end

   assign carry_o = carry_ff;
   assign flag_o  = flag_ff;

endmodule

>>> src/event_timer_bank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event timer bank
// A bank of countdown timers built as a chain of timer cells.
// ----------------------------------------------------------------------------
// A request (tick, start, stop, restart, read, query) is taken on req_data
// at a clock edge where start is high and busy is low. The request then
// walks the chain of CHANNELS cells, one cell per cycle; each cell owns one
// timer (count, reload, expiry flag) and updates it as the request passes,
// adding its part to the response (grant, count, expiry).
// The response appears on rsp_data for exactly one cycle with rsp_valid
// high, when the request leaves the register of the last cell; all_flags
// then holds every timer's flag after the request. busy is high from the
// accepting edge to the end of the response cycle, so a new request is
// taken only once the response of the last one has been shown.
// There is no backpressure: the receiver must take rsp_data when it is
// shown. Synchronous reset clears every count, reload and flag and drops
// any request in flight.
// ----------------------------------------------------------------------------
module event_timer_bank import etb_pkg::*; #(
   parameter int CHANNELS = CHANNELS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  etb_req_type req_data,
   output logic        rsp_valid,
   output etb_rsp_type rsp_data
);

   etb_carry_type       link [0:CHANNELS];
   logic [SLOTS-1:0]    flags;
   logic [CHANNELS:0]   chain_valid;
   logic                busy_ff, busy_in;
   logic                accept;

   assign accept = start && !busy_ff;

   always_comb begin
      link[0]                 = '0;
      link[0].valid           = accept;
      link[0].req             = req_data;
   end

   genvar gi;
   generate
      for (gi = 0; gi < CHANNELS; gi++) begin : g_cell
         etb_cell #(.INDEX(gi)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .carry_i (link[gi]),
            .carry_o (link[gi+1]),
            .flag_o  (flags[gi])
         );
      end
      for (gi = CHANNELS; gi < SLOTS; gi++) begin : g_unused
         assign flags[gi] = 1'b0;
      end
      for (gi = 0; gi <= CHANNELS; gi++) begin : g_valid
         assign chain_valid[gi] = link[gi].valid;
      end
   endgenerate

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (link[CHANNELS].valid) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy                     = busy_ff;
   assign rsp_valid                = link[CHANNELS].valid;
   assign rsp_data.granted         = link[CHANNELS].granted;
   assign rsp_data.granted_channel = link[CHANNELS].granted_channel;
   assign rsp_data.count_value     = link[CHANNELS].count_value;
   assign rsp_data.expired         = link[CHANNELS].expired;
   assign rsp_data.all_flags       = flags;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      $onehot0(chain_valid))
      else $error("more than one request in the cell chain");

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy_ff)
      else $error("response without a request in flight");

   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("busy not raised after accept");

   a_grant_only_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && link[CHANNELS].granted) |-> (link[CHANNELS].req.mode == MODE_START))
      else $error("grant outside a start request");

   a_count_only_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && link[CHANNELS].req.mode != MODE_READ) |-> (rsp_data.count_value == '0))
      else $error("count value outside a read request");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event timer bank testbench
// Drives a short table of directed requests, then several hundred random
// requests in three sender idling phases. Every response is checked field by
// field against its typed row or a cycle-free bank model in the testbench.
// ----------------------------------------------------------------------------
module testbench;
   import etb_pkg::*;

   localparam int         NUM_CH         = CHANNELS_DEFAULT;
   localparam int         RANDOM_ITEMS   = 134;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam logic [2:0] MODE_SPARE_6   = 3'd6;
   localparam logic [2:0] MODE_SPARE_7   = 3'd7;

   typedef struct packed {
      etb_req_type req;
      logic        typed;
      etb_rsp_type rsp;
   } stim_row_t;

   logic        clock;
   logic        reset    = 1'b1;
   logic        start    = 1'b0;
   etb_req_type req_data = '0;
   logic        busy;
   logic        rsp_valid;
   etb_rsp_type rsp_data;

   logic [15:0] model_counts  [NUM_CH];
   logic [15:0] model_reloads [NUM_CH];
   logic [7:0]  model_flags;

   etb_rsp_type due_responses [$];
   stim_row_t   directed_rows [$];
   etb_rsp_type oldest;
   int          mismatch_count = 0;
   int          idle_cycles    = 0;

   event_timer_bank dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic etb_req_type mk_req(logic [2:0] mode, logic [2:0] ch,
                                          logic [15:0] per, logic rec, logic clr);
      etb_req_type r;
      r.mode       = mode;
      r.channel    = ch;
      r.period     = per;
      r.recurring  = rec;
      r.clear_flag = clr;
      return r;
   endfunction

   function automatic etb_rsp_type mk_rsp(logic g, logic [2:0] gch, logic [15:0] cv,
                                          logic ex, logic [7:0] fl);
      etb_rsp_type p;
      p.granted         = g;
      p.granted_channel = gch;
      p.count_value     = cv;
      p.expired         = ex;
      p.all_flags       = fl;
      return p;
   endfunction

   function automatic void load_timer(int ch, logic [15:0] per, logic rec);
      model_counts[ch] = per;
      if (rec) begin
         model_reloads[ch] = per;
      end
      model_flags[ch] = 1'b0;
   endfunction

   // advance the timer bank by one request and return its response
   function automatic etb_rsp_type timer_bank_next(etb_req_type r);
      etb_rsp_type p;
      logic [15:0] nxt;
      bit          found;
      p     = '0;
      found = 0;
      case (r.mode)
         MODE_TICK: begin
            for (int i = 0; i < NUM_CH; i++) begin
               if (model_counts[i] != 16'd0) begin
                  nxt = model_counts[i] - 16'd1;
                  if (nxt == 16'd0) begin
                     nxt            = model_reloads[i];
                     model_flags[i] = 1'b1;
                  end
                  model_counts[i] = nxt;
               end
            end
         end
         MODE_START: begin
            for (int i = 0; i < NUM_CH; i++) begin
               if (!found && model_counts[i] == 16'd0 && model_reloads[i] == 16'd0) begin
                  load_timer(i, r.period, r.recurring);
                  p.granted         = 1'b1;
                  p.granted_channel = 3'(i);
                  found             = 1;
               end
            end
         end
         MODE_STOP: begin
            if (r.channel < NUM_CH) begin
               model_counts[r.channel]  = 16'd0;
               model_reloads[r.channel] = 16'd0;
            end
         end
         MODE_RESTART: begin
            if (r.channel < NUM_CH) begin
               load_timer(r.channel, r.period, r.recurring);
            end
         end
         MODE_READ: begin
            if (r.channel < NUM_CH) begin
               p.count_value = model_counts[r.channel];
            end
         end
         MODE_QUERY: begin
            if (r.channel < NUM_CH) begin
               p.expired = model_flags[r.channel];
               if (r.clear_flag) begin
                  model_flags[r.channel] = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
      p.all_flags = model_flags;
      return p;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // present one request, idling at random, and hold it until accepted
   task automatic send_request(etb_req_type r, int idle_pct, logic typed,
                               etb_rsp_type typed_rsp);
      bit          accepted;
      etb_rsp_type predicted;
      accepted = 0;
      while (!accepted) begin
         if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
         end else begin
            start    <= 1'b1;
            req_data <= r;
         end
         @(posedge clock);
         accepted = start && !busy;
      end
      predicted = timer_bank_next(r);
      due_responses.push_back(typed ? typed_rsp : predicted);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid) begin
            if (due_responses.size() == 0) begin
               report_mismatch("response with nothing pending", rsp_data, 0);
            end else begin
               oldest = due_responses.pop_front();
               if (rsp_data.granted !== oldest.granted)
                  report_mismatch("granted", rsp_data.granted, oldest.granted);
               if (rsp_data.granted_channel !== oldest.granted_channel)
                  report_mismatch("granted_channel", rsp_data.granted_channel,
                                  oldest.granted_channel);
               if (rsp_data.count_value !== oldest.count_value)
                  report_mismatch("count_value", rsp_data.count_value, oldest.count_value);
               if (rsp_data.expired !== oldest.expired)
                  report_mismatch("expired", rsp_data.expired, oldest.expired);
               if (rsp_data.all_flags !== oldest.all_flags)
                  report_mismatch("all_flags", rsp_data.all_flags, oldest.all_flags);
            end
         end
         if (rsp_valid || (start && !busy)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   initial begin
      int          idle_pct;
      int          k;
      etb_req_type r;
      stim_row_t   row;

      for (int i = 0; i < NUM_CH; i++) begin
         model_counts[i]  = 16'd0;
         model_reloads[i] = 16'd0;
      end
      model_flags = 8'd0;

      directed_rows.push_back({mk_req(MODE_READ, 3'd0, 16'd0, 1'b0, 1'b0), 1'b1,
                               mk_rsp(1'b0, 3'd0, 16'd0, 1'b0, 8'h00)});
      directed_rows.push_back({mk_req(MODE_QUERY, 3'd7, 16'hFFFF, 1'b1, 1'b1), 1'b1,
                               mk_rsp(1'b0, 3'd0, 16'd0, 1'b0, 8'h00)});
      directed_rows.push_back({mk_req(MODE_TICK, 3'd0, 16'd0, 1'b0, 1'b0), 1'b1,
                               mk_rsp(1'b0, 3'd0, 16'd0, 1'b0, 8'h00)});
      directed_rows.push_back({mk_req(MODE_START, 3'd0, 16'd1, 1'b0, 1'b0), 1'b1,
                               mk_rsp(1'b1, 3'd0, 16'd0, 1'b0, 8'h00)});
      directed_rows.push_back({mk_req(MODE_TICK, 3'd0, 16'd0, 1'b0, 1'b0), 1'b1,
                               mk_rsp(1'b0, 3'd0, 16'd0, 1'b0, 8'h01)});
      directed_rows.push_back({mk_req(MODE_QUERY, 3'd0, 16'd0, 1'b0, 1'b1), 1'b1,
                               mk_rsp(1'b0, 3'd0, 16'd0, 1'b1, 8'h00)});
      directed_rows.push_back({mk_req(MODE_START, 3'd0, 16'd0, 1'b0, 1'b0), 1'b1,
                               mk_rsp(1'b1, 3'd0, 16'd0, 1'b0, 8'h00)});
      directed_rows.push_back({mk_req(MODE_START, 3'd0, 16'hFFFF, 1'b1, 1'b0), 1'b1,
                               mk_rsp(1'b1, 3'd0, 16'd0, 1'b0, 8'h00)});
      directed_rows.push_back({mk_req(MODE_READ, 3'd0, 16'd0, 1'b0, 1'b0), 1'b1,
                               mk_rsp(1'b0, 3'd0, 16'hFFFF, 1'b0, 8'h00)});
      directed_rows.push_back({mk_req(MODE_START, 3'd0, 16'd3, 1'b1, 1'b0), 1'b0,
                               etb_rsp_type'(0)});
      directed_rows.push_back({mk_req(MODE_RESTART, 3'd1, 16'd2, 1'b0, 1'b1), 1'b0,
                               etb_rsp_type'(0)});
      directed_rows.push_back({mk_req(MODE_TICK, 3'd0, 16'd0, 1'b0, 1'b0), 1'b0,
                               etb_rsp_type'(0)});
      directed_rows.push_back({mk_req(MODE_TICK, 3'd0, 16'd0, 1'b0, 1'b0), 1'b0,
                               etb_rsp_type'(0)});
      directed_rows.push_back({mk_req(MODE_QUERY, 3'd1, 16'd0, 1'b0, 1'b0), 1'b0,
                               etb_rsp_type'(0)});
      directed_rows.push_back({mk_req(MODE_STOP, 3'd0, 16'd0, 1'b0, 1'b0), 1'b0,
                               etb_rsp_type'(0)});
      directed_rows.push_back({mk_req(MODE_START, 3'd0, 16'hAAAA, 1'b1, 1'b0), 1'b0,
                               etb_rsp_type'(0)});
      directed_rows.push_back({mk_req(MODE_START, 3'd0, 16'h5555, 1'b1, 1'b1), 1'b0,
                               etb_rsp_type'(0)});
      directed_rows.push_back({mk_req(MODE_START, 3'd0, 16'h8000, 1'b0, 1'b0), 1'b0,
                               etb_rsp_type'(0)});
      directed_rows.push_back({mk_req(MODE_START, 3'd0, 16'h7FFF, 1'b1, 1'b0), 1'b0,
                               etb_rsp_type'(0)});
      directed_rows.push_back({mk_req(MODE_START, 3'd0, 16'd100, 1'b1, 1'b0), 1'b0,
                               etb_rsp_type'(0)});
      directed_rows.push_back({mk_req(MODE_START, 3'd0, 16'd5, 1'b1, 1'b0), 1'b0,
                               etb_rsp_type'(0)});
      directed_rows.push_back({mk_req(MODE_START, 3'd0, 16'd2, 1'b1, 1'b0), 1'b0,
                               etb_rsp_type'(0)});
      directed_rows.push_back({mk_req(MODE_START, 3'd0, 16'd9, 1'b1, 1'b0), 1'b0,
                               etb_rsp_type'(0)});
      directed_rows.push_back({mk_req(MODE_SPARE_6, 3'd5, 16'h1234, 1'b1, 1'b1), 1'b0,
                               etb_rsp_type'(0)});
      directed_rows.push_back({mk_req(MODE_SPARE_7, 3'd2, 16'hFFFF, 1'b0, 1'b1), 1'b0,
                               etb_rsp_type'(0)});

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 36 : (phase == 1) ? 80 : 0;
         if (phase == 0) begin
            foreach (directed_rows[i]) begin
               row = directed_rows[i];
               send_request(row.req, idle_pct, row.typed, row.rsp);
            end
         end
         for (int n = 0; n < RANDOM_ITEMS; n++) begin
            k = $urandom_range(99);
            r.mode = (k < 34) ? MODE_TICK    : (k < 50) ? MODE_START :
                     (k < 60) ? MODE_STOP    : (k < 74) ? MODE_RESTART :
                     (k < 86) ? MODE_READ    : (k < 98) ? MODE_QUERY :
                     (k < 99) ? MODE_SPARE_6 : MODE_SPARE_7;
            r.channel = 3'($urandom_range(7));
            k = $urandom_range(9);
            r.period = (k == 0) ? 16'd0 :
                       (k < 7)  ? 16'($urandom_range(6, 1)) :
                       (k < 9)  ? 16'($urandom_range(40, 7)) : 16'($urandom());
            r.recurring  = 1'($urandom_range(1));
            r.clear_flag = 1'($urandom_range(1));
            send_request(r, idle_pct, 1'b0, '0);
         end
         // drain before the next idling phase
         start <= 1'b0;
         while (due_responses.size() != 0) @(posedge clock);
      end

      repeat (2 * NUM_CH + 4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

>>> files.f
src/etb_pkg.sv
src/etb_cell.sv
src/event_timer_bank.sv
test/testbench.sv
